// ===== rtl/script_token_lexer_core_defines.svh =====
// ----------------------------------------------------------------------------
// Script token lexer assertion macros
// Shared macros for the concurrent checks on the lexer ports.
// ----------------------------------------------------------------------------
`ifndef SCRIPT_TOKEN_LEXER_CORE_DEFINES_SVH
`define SCRIPT_TOKEN_LEXER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lexer check failed");

// Next-cycle implication, disabled while reset is asserted.
`define STL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lexer check failed");

`endif

// ===== rtl/stl_pkg.sv =====
// ----------------------------------------------------------------------------
// Script token lexer package
// Types, codes, character constants and classifiers shared by the lexer.
// ----------------------------------------------------------------------------
package stl_pkg;

    localparam int LINE_BITS  = 24;
    localparam int OUT_LINE_W = 24;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef logic [LINE_BITS-1:0] line_t;
    typedef logic [4:0]           kind_t;
    typedef logic [2:0]           err_t;

    localparam line_t LINE_MAX = '1;

    localparam kind_t KIND_END    = 5'd0;
    localparam kind_t KIND_IDENT  = 5'd1;
    localparam kind_t KIND_NUMBER = 5'd2;
    localparam kind_t KIND_STRING = 5'd3;
    localparam kind_t KIND_ASSIGN = 5'd4;
    localparam kind_t KIND_LT     = 5'd6;
    localparam kind_t KIND_GT     = 5'd8;
    localparam kind_t KIND_NE     = 5'd10;
    localparam kind_t KIND_AMP    = 5'd11;
    localparam kind_t KIND_BAR    = 5'd12;
    localparam kind_t KIND_SEMI   = 5'd13;
    localparam kind_t KIND_LPAREN = 5'd14;
    localparam kind_t KIND_RPAREN = 5'd15;
    localparam kind_t KIND_COMMA  = 5'd16;
    localparam kind_t KIND_LBRACE = 5'd17;
    localparam kind_t KIND_RBRACE = 5'd18;
    localparam kind_t KIND_PLUS   = 5'd19;
    localparam kind_t KIND_MINUS  = 5'd20;
    localparam kind_t KIND_STAR   = 5'd21;
    localparam kind_t KIND_SLASH  = 5'd22;

    localparam err_t ERR_NONE    = 3'd0;
    localparam err_t ERR_CHAR    = 3'd1;
    localparam err_t ERR_NUMBER  = 3'd2;
    localparam err_t ERR_BANG    = 3'd3;
    localparam err_t ERR_UNTERM  = 3'd4;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_UNDER  = 8'h5F;

    typedef enum logic [2:0] {
        M_IDLE,
        M_IDENT,
        M_NUMBER,
        M_STRING,
        M_OP,
        M_COMMENT,
        M_ERROR
    } mode_t;

    typedef struct packed {
        mode_t      mode;
        logic [7:0] held_char;
        logic       held_valid;
        kind_t      held_kind;
        logic       held_is_first;
        logic       dot_seen;
        line_t      cur_line;
        line_t      tok_line;
    } lex_state_t;

    localparam lex_state_t STATE_RESET = '{
        mode:          M_IDLE,
        held_char:     8'h00,
        held_valid:    1'b0,
        held_kind:     KIND_END,
        held_is_first: 1'b0,
        dot_seen:      1'b0,
        cur_line:      line_t'(1),
        tok_line:      line_t'(1)
    };

    typedef struct packed {
        kind_t                 kind;
        logic [7:0]            ch;
        logic                  present;
        logic                  first;
        logic                  last;
        logic [OUT_LINE_W-1:0] line;
        err_t                  err;
    } tok_t;

    typedef struct packed {
        logic [1:0]     count;
        tok_t [1:0]     item;
    } step_out_t;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic kind_t punct_kind(input logic [7:0] c);
        kind_t k;
        case (c)
            8'h26:   k = KIND_AMP;
            8'h7C:   k = KIND_BAR;
            8'h3B:   k = KIND_SEMI;
            8'h28:   k = KIND_LPAREN;
            8'h29:   k = KIND_RPAREN;
            8'h2C:   k = KIND_COMMA;
            8'h7B:   k = KIND_LBRACE;
            8'h7D:   k = KIND_RBRACE;
            8'h2B:   k = KIND_PLUS;
            8'h2D:   k = KIND_MINUS;
            8'h2A:   k = KIND_STAR;
            8'h2F:   k = KIND_SLASH;
            default: k = KIND_END;
        endcase
        return k;
    endfunction

    function automatic tok_t make_tok(input kind_t kind, input logic [7:0] ch,
                                      input logic present, input logic first,
                                      input logic last, input line_t line,
                                      input err_t err);
        tok_t t;
        t.kind    = kind;
        t.ch      = ch;
        t.present = present;
        t.first   = first;
        t.last    = last;
        t.line    = OUT_LINE_W'(line);
        t.err     = err;
        return t;
    endfunction

endpackage

// ===== rtl/stl_step.sv =====
// ----------------------------------------------------------------------------
// Script token lexer step logic
// Classifies one source byte against the scan state and forms up to two
// token items together with the next scan state.
// ----------------------------------------------------------------------------
module stl_step (
    input  stl_pkg::lex_state_t state,
    input  logic [7:0]          text_byte,
    input  logic                end_of_text,
    output stl_pkg::lex_state_t state_next,
    output stl_pkg::step_out_t  result
);
    import stl_pkg::*;

    lex_state_t ns;
    step_out_t  so;
    logic [1:0] n;
    logic       do_idle;
    logic       fin;
    logic [7:0] c;
    kind_t      k2;
    kind_t      pk;

    always_comb
    begin
        ns      = state;
        so      = '0;
        n       = 2'd0;
        do_idle = 1'b0;
        c       = text_byte;
        fin     = end_of_text || (c == CH_NUL);
        k2      = KIND_END;
        pk      = punct_kind(c);

        if (fin)
        begin
            case (state.mode)
                M_IDENT, M_NUMBER:
                begin
                    so.item[n[0]] = make_tok(ns.held_kind, ns.held_char, 1'b1,
                                             ns.held_is_first, 1'b1, ns.tok_line, ERR_NONE);
                    n = n + 2'd1;
                end
                M_OP:
                begin
                    if (ns.held_char == CH_BANG)
                    begin
                        so.item[n[0]] = make_tok(KIND_END, CH_BANG, 1'b0, 1'b1, 1'b1,
                                                 ns.cur_line, ERR_BANG);
                    end
                    else
                    begin
                        so.item[n[0]] = make_tok(ns.held_kind, ns.held_char, 1'b1,
                                                 ns.held_is_first, 1'b1, ns.tok_line,
                                                 ERR_NONE);
                    end
                    n = n + 2'd1;
                end
                M_STRING:
                begin
                    if (ns.held_valid)
                    begin
                        so.item[n[0]] = make_tok(ns.held_kind, ns.held_char, 1'b1,
                                                 ns.held_is_first, 1'b1, ns.tok_line,
                                                 ERR_NONE);
                        n = n + 2'd1;
                    end
                    so.item[n[0]] = make_tok(KIND_END, CH_NUL, 1'b0, 1'b1, 1'b1,
                                             ns.cur_line, ERR_UNTERM);
                    n = n + 2'd1;
                end
                default:
                begin
                end
            endcase
            if (state.mode != M_STRING)
            begin
                so.item[n[0]] = make_tok(KIND_END, CH_NUL, 1'b0, 1'b1, 1'b1,
                                         ns.cur_line, ERR_NONE);
                n = n + 2'd1;
            end
            ns = STATE_RESET;
        end
        else
        begin
            if (c == CH_LF && ns.cur_line != LINE_MAX)
            begin
                ns.cur_line = ns.cur_line + line_t'(1);
            end

            case (state.mode)
                M_ERROR:
                begin
                end
                M_COMMENT:
                begin
                    if (c == CH_DOLLAR)
                    begin
                        ns.mode = M_IDLE;
                    end
                end
                M_STRING:
                begin
                    if (c == CH_QUOTE)
                    begin
                        if (ns.held_valid)
                        begin
                            so.item[n[0]] = make_tok(ns.held_kind, ns.held_char, 1'b1,
                                                     ns.held_is_first, 1'b1, ns.tok_line,
                                                     ERR_NONE);
                        end
                        else
                        begin
                            so.item[n[0]] = make_tok(KIND_STRING, CH_NUL, 1'b0, 1'b1, 1'b1,
                                                     ns.tok_line, ERR_NONE);
                        end
                        n = n + 2'd1;
                        ns.held_valid = 1'b0;
                        ns.mode       = M_IDLE;
                    end
                    else
                    begin
                        if (ns.held_valid)
                        begin
                            so.item[n[0]] = make_tok(ns.held_kind, ns.held_char, 1'b1,
                                                     ns.held_is_first, 1'b0, ns.tok_line,
                                                     ERR_NONE);
                            n = n + 2'd1;
                        end
                        ns.held_is_first = !state.held_valid;
                        ns.held_char     = c;
                        ns.held_kind     = KIND_STRING;
                        ns.held_valid    = 1'b1;
                    end
                end
                M_IDENT:
                begin
                    so.item[n[0]] = make_tok(ns.held_kind, ns.held_char, 1'b1,
                                             ns.held_is_first, 1'b0, ns.tok_line, ERR_NONE);
                    if (is_alpha(c) || is_digit(c) || c == CH_UNDER)
                    begin
                        n = n + 2'd1;
                        ns.held_char     = c;
                        ns.held_kind     = KIND_IDENT;
                        ns.held_is_first = 1'b0;
                        ns.held_valid    = 1'b1;
                    end
                    else
                    begin
                        so.item[n[0]].last = 1'b1;
                        n = n + 2'd1;
                        ns.held_valid = 1'b0;
                        ns.mode       = M_IDLE;
                        do_idle       = 1'b1;
                    end
                end
                M_NUMBER:
                begin
                    so.item[n[0]] = make_tok(ns.held_kind, ns.held_char, 1'b1,
                                             ns.held_is_first, 1'b0, ns.tok_line, ERR_NONE);
                    if (is_digit(c) || c == CH_DOT)
                    begin
                        if (c == CH_DOT && ns.dot_seen)
                        begin
                            so.item[n[0]].last = 1'b1;
                            n = n + 2'd1;
                            so.item[n[0]] = make_tok(KIND_END, c, 1'b0, 1'b1, 1'b1,
                                                     ns.cur_line, ERR_NUMBER);
                            n = n + 2'd1;
                            ns.mode       = M_ERROR;
                            ns.held_valid = 1'b0;
                        end
                        else
                        begin
                            if (c == CH_DOT)
                            begin
                                ns.dot_seen = 1'b1;
                            end
                            n = n + 2'd1;
                            ns.held_char     = c;
                            ns.held_kind     = KIND_NUMBER;
                            ns.held_is_first = 1'b0;
                            ns.held_valid    = 1'b1;
                        end
                    end
                    else
                    begin
                        so.item[n[0]].last = 1'b1;
                        n = n + 2'd1;
                        ns.held_valid = 1'b0;
                        ns.mode       = M_IDLE;
                        do_idle       = 1'b1;
                    end
                end
                M_OP:
                begin
                    if (c == CH_EQ)
                    begin
                        k2 = (ns.held_char == CH_BANG) ? KIND_NE : ns.held_kind + 5'd1;
                        so.item[n[0]] = make_tok(k2, ns.held_char, 1'b1, 1'b1, 1'b0,
                                                 ns.tok_line, ERR_NONE);
                        n = n + 2'd1;
                        so.item[n[0]] = make_tok(k2, c, 1'b1, 1'b0, 1'b1,
                                                 ns.tok_line, ERR_NONE);
                        n = n + 2'd1;
                        ns.held_valid = 1'b0;
                        ns.mode       = M_IDLE;
                    end
                    else if (ns.held_char == CH_BANG)
                    begin
                        so.item[n[0]] = make_tok(KIND_END, CH_BANG, 1'b0, 1'b1, 1'b1,
                                                 ns.cur_line, ERR_BANG);
                        n = n + 2'd1;
                        ns.mode       = M_ERROR;
                        ns.held_valid = 1'b0;
                    end
                    else
                    begin
                        so.item[n[0]] = make_tok(ns.held_kind, ns.held_char, 1'b1,
                                                 ns.held_is_first, 1'b1, ns.tok_line,
                                                 ERR_NONE);
                        n = n + 2'd1;
                        ns.held_valid = 1'b0;
                        ns.mode       = M_IDLE;
                        do_idle       = 1'b1;
                    end
                end
                default:
                begin
                    ns.mode = M_IDLE;
                    do_idle = 1'b1;
                end
            endcase

            if (do_idle)
            begin
                if (c == CH_SPACE || c == CH_LF || c == CH_TAB)
                begin
                end
                else if (c == CH_DOLLAR)
                begin
                    ns.mode = M_COMMENT;
                end
                else if (c == CH_QUOTE)
                begin
                    ns.mode       = M_STRING;
                    ns.held_valid = 1'b0;
                    ns.tok_line   = ns.cur_line;
                end
                else if (is_alpha(c) || c == CH_UNDER || is_digit(c) || c == CH_EQ
                         || c == CH_LT || c == CH_GT || c == CH_BANG)
                begin
                    ns.held_char     = c;
                    ns.held_is_first = 1'b1;
                    ns.held_valid    = 1'b1;
                    ns.tok_line      = ns.cur_line;
                    if (is_digit(c))
                    begin
                        ns.mode      = M_NUMBER;
                        ns.dot_seen  = 1'b0;
                        ns.held_kind = KIND_NUMBER;
                    end
                    else if (c == CH_EQ)
                    begin
                        ns.mode      = M_OP;
                        ns.held_kind = KIND_ASSIGN;
                    end
                    else if (c == CH_LT)
                    begin
                        ns.mode      = M_OP;
                        ns.held_kind = KIND_LT;
                    end
                    else if (c == CH_GT)
                    begin
                        ns.mode      = M_OP;
                        ns.held_kind = KIND_GT;
                    end
                    else if (c == CH_BANG)
                    begin
                        ns.mode      = M_OP;
                        ns.held_kind = KIND_NE;
                    end
                    else
                    begin
                        ns.mode      = M_IDENT;
                        ns.held_kind = KIND_IDENT;
                    end
                end
                else if (c == CH_DOT)
                begin
                    so.item[n[0]] = make_tok(KIND_END, c, 1'b0, 1'b1, 1'b1,
                                             ns.cur_line, ERR_NUMBER);
                    n = n + 2'd1;
                    ns.mode       = M_ERROR;
                    ns.held_valid = 1'b0;
                end
                else if (pk != KIND_END)
                begin
                    so.item[n[0]] = make_tok(pk, c, 1'b1, 1'b1, 1'b1,
                                             ns.cur_line, ERR_NONE);
                    n = n + 2'd1;
                end
                else
                begin
                    so.item[n[0]] = make_tok(KIND_END, c, 1'b0, 1'b1, 1'b1,
                                             ns.cur_line, ERR_CHAR);
                    n = n + 2'd1;
                    ns.mode       = M_ERROR;
                    ns.held_valid = 1'b0;
                end
            end
        end

        so.count   = n;
        state_next = ns;
        result     = so;
    end

endmodule

// ===== rtl/stl_out_fifo.sv =====
// ----------------------------------------------------------------------------
// Script token lexer result queue
// Small register queue that takes up to two token items per cycle and
// hands out one per cycle while the reader is ready.
// ----------------------------------------------------------------------------
module stl_out_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  stl_pkg::step_out_t push_data,
    output logic               has_room,
    output logic               head_valid,
    input  logic               head_ready,
    output stl_pkg::tok_t      head
);
    import stl_pkg::*;

    tok_t             mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] push_cnt;
    logic             pop;

    assign push_cnt   = push ? CNT_W'(push_data.count) : '0;
    assign head_valid = (count_reg != '0);
    assign pop        = head_valid && head_ready;
    assign has_room   = (count_reg <= CNT_W'(FIFO_DEPTH - 2));
    assign head       = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_cnt);
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + push_cnt - (pop ? CNT_W'(1) : CNT_W'(0));
    end

    always_ff @(posedge clk)
    begin
        if (push && push_data.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push_data.item[0];
        end
        if (push && push_data.count == 2'd2)
        begin
            mem[wr_ptr_reg + PTR_W'(1)] <= push_data.item[1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/script_token_lexer_core.sv =====
// ----------------------------------------------------------------------------
// Script token lexer core
// Turns a stream of source bytes into a stream of token characters with
// token kind, first and last marks, line number and error code.
//
// Channel   Direction  Contents
// s_axis    in         tdata: text_byte; tlast: end_of_text
// m_axis    out        tdata: token_char, line_number; tuser: kind, flags, error
//
// One source byte is taken per cycle; each transfer yields zero, one or two
// result transfers, which wait in a four-entry result queue.
// Input is taken whenever at most two results are queued, so a stream that
// averages one result per byte runs at one byte per cycle.
// The output drains one result per cycle; a stall on m_axis fills the queue
// and then holds s_axis_tready low.
// Reset returns the scan state to idle at line one and empties the queue.
// ----------------------------------------------------------------------------
module script_token_lexer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  logic        s_axis_tlast,   // end_of_text
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] token_char, [31:8] line_number
    output logic        m_axis_tlast,   // token_last
    output logic [9:0]  m_axis_tuser    // [4:0] token_kind, [5] char_present,
                                        // [6] token_first, [9:7] error_code
);
    import stl_pkg::*;

    lex_state_t state_reg;
    lex_state_t state_next;
    step_out_t  step_res;
    tok_t       head;
    logic       accept;

    assign accept = s_axis_tvalid && s_axis_tready;

    stl_step u_step (
        .state       (state_reg),
        .text_byte   (s_axis_tdata),
        .end_of_text (s_axis_tlast),
        .state_next  (state_next),
        .result      (step_res)
    );

    stl_out_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_data  (step_res),
        .has_room   (s_axis_tready),
        .head_valid (m_axis_tvalid),
        .head_ready (m_axis_tready),
        .head       (head)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    assign m_axis_tdata = {head.line, head.ch};
    assign m_axis_tlast = head.last;
    assign m_axis_tuser = {head.err, head.first, head.present, head.kind};

endmodule

// ===== rtl/stl_checker.sv =====
// ----------------------------------------------------------------------------
// Script token lexer port checker
// Concurrent checks on the lexer ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "script_token_lexer_core_defines.svh"

module stl_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [7:0]  s_axis_tdata,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic [9:0]  m_axis_tuser
);
    import stl_pkg::*;

    logic        out_stall;
    logic [42:0] out_bus;
    logic        end_kind;
    logic        end_flags;
    logic        in_end;

    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign out_bus   = {m_axis_tlast, m_axis_tuser, m_axis_tdata};
    assign end_kind  = m_axis_tvalid && (m_axis_tuser[4:0] == KIND_END);
    assign end_flags = m_axis_tlast && m_axis_tuser[6] && !m_axis_tuser[5];
    assign in_end    = s_axis_tvalid && s_axis_tready
                       && (s_axis_tlast || s_axis_tdata == CH_NUL);

    `STL_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid)
    `STL_ASSERT_NEXT(a_out_stable, out_stall, $stable(out_bus))
    `STL_ASSERT_NOW(a_kind_end_single, end_kind, end_flags)
    `STL_ASSERT_NOW(a_line_nonzero, m_axis_tvalid, m_axis_tdata[31:8] != 24'd0)
    `STL_ASSERT_NEXT(a_end_has_item, in_end, m_axis_tvalid)

endmodule

bind script_token_lexer_core stl_checker u_stl_checker (.*);

// ===== dv/script_token_lexer_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Script token lexer core testbench
// Drives source text through s_axis and checks every token character
// transfer on m_axis against a cycle-free model of the lexer or, for some
// directed rows, a fixed expected item. A short directed table covers end
// of text, operators, strings, comments and every error code, then random
// texts of well-formed tokens with some noise; both sides idle and stall at random.
// ----------------------------------------------------------------------------
module script_token_lexer_core_test;

    import stl_pkg::*;

    localparam int DIR_LEN     = 30;
    localparam int RAND_ITEMS  = 600;
    localparam int RX_HOLD_AT  = 250;
    localparam int RX_HOLD_LEN = 300;
    localparam int QUIET_LIMIT = 3000;
    localparam int TAIL_CYCLES = 20;

    typedef struct packed {
        logic [7:0] text;
        logic       eot;
        logic       fixed;
        tok_t       want;
    } src_row_t;

    localparam src_row_t DIRECTED [0:DIR_LEN-1] = '{
        '{8'hFF,     1'b1, 1'b1, '{KIND_END, CH_NUL, 1'b0, 1'b1, 1'b1, 24'd1, ERR_NONE}},
        '{"a",       1'b0, 1'b0, '0},
        '{"9",       1'b0, 1'b0, '0},
        '{CH_EQ,     1'b0, 1'b0, '0},
        '{CH_EQ,     1'b0, 1'b0, '0},
        '{CH_QUOTE,  1'b0, 1'b0, '0},
        '{CH_QUOTE,  1'b0, 1'b1, '{KIND_STRING, CH_NUL, 1'b0, 1'b1, 1'b1, 24'd1, ERR_NONE}},
        '{"1",       1'b0, 1'b0, '0},
        '{CH_DOT,    1'b0, 1'b0, '0},
        '{"5",       1'b0, 1'b0, '0},
        '{CH_DOT,    1'b0, 1'b0, '0},
        '{CH_NUL,    1'b0, 1'b1, '{KIND_END, CH_NUL, 1'b0, 1'b1, 1'b1, 24'd1, ERR_NONE}},
        '{CH_LF,     1'b0, 1'b0, '0},
        '{CH_BANG,   1'b0, 1'b0, '0},
        '{"x",       1'b0, 1'b1, '{KIND_END, CH_BANG, 1'b0, 1'b1, 1'b1, 24'd2, ERR_BANG}},
        '{8'h80,     1'b1, 1'b1, '{KIND_END, CH_NUL, 1'b0, 1'b1, 1'b1, 24'd2, ERR_NONE}},
        '{CH_DOLLAR, 1'b0, 1'b0, '0},
        '{"q",       1'b0, 1'b0, '0},
        '{CH_DOLLAR, 1'b0, 1'b0, '0},
        '{CH_DOLLAR, 1'b0, 1'b0, '0},
        '{CH_DOLLAR, 1'b0, 1'b0, '0},
        '{CH_LT,     1'b0, 1'b0, '0},
        '{CH_NUL,    1'b0, 1'b0, '0},
        '{CH_QUOTE,  1'b0, 1'b0, '0},
        '{"s",       1'b0, 1'b0, '0},
        '{CH_NUL,    1'b1, 1'b0, '0},
        '{8'h80,     1'b0, 1'b1, '{KIND_END, 8'h80, 1'b0, 1'b1, 1'b1, 24'd1, ERR_CHAR}},
        '{CH_NUL,    1'b0, 1'b1, '{KIND_END, CH_NUL, 1'b0, 1'b1, 1'b1, 24'd1, ERR_NONE}},
        '{CH_DOT,    1'b0, 1'b1, '{KIND_END, CH_DOT, 1'b0, 1'b1, 1'b1, 24'd1, ERR_NUMBER}},
        '{CH_NUL,    1'b1, 1'b1, '{KIND_END, CH_NUL, 1'b0, 1'b1, 1'b1, 24'd1, ERR_NONE}}
    };

    localparam logic [7:0] PUNCT_CHARS [0:11] =
        '{"&", "|", ";", "(", ")", ",", "{", "}", "+", "-", "*", "/"};
    localparam logic [7:0] BLANK_CHARS [0:2] = '{CH_SPACE, CH_LF, CH_TAB};
    localparam logic [7:0] OP_CHARS [0:3] = '{CH_EQ, CH_LT, CH_GT, CH_BANG};

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic [9:0]  m_axis_tuser;

    mode_t      lx_mode;
    logic [7:0] lx_hold_ch;
    logic       lx_hold_vld;
    kind_t      lx_hold_kind;
    logic       lx_hold_first;
    logic       lx_dot;
    line_t      lx_line;
    line_t      lx_tok_line;
    tok_t       step_tok [0:1];
    int         step_cnt;

    src_row_t   stim_q [$];
    tok_t       token_q [$];
    int         accept_idx = 0;
    int         fail_cnt = 0;
    int         n_results = 0;
    int         n_err_items = 0;
    int         n_texts = 0;
    int         quiet_cyc = 0;

    script_token_lexer_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_numeral(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic kind_t single_kind(input logic [7:0] c);
        kind_t k;
        case (c)
            "&":     k = KIND_AMP;
            "|":     k = KIND_BAR;
            ";":     k = KIND_SEMI;
            "(":     k = KIND_LPAREN;
            ")":     k = KIND_RPAREN;
            ",":     k = KIND_COMMA;
            "{":     k = KIND_LBRACE;
            "}":     k = KIND_RBRACE;
            "+":     k = KIND_PLUS;
            "-":     k = KIND_MINUS;
            "*":     k = KIND_STAR;
            "/":     k = KIND_SLASH;
            default: k = KIND_END;
        endcase
        return k;
    endfunction

    task automatic lexer_clear();
        lx_mode       = M_IDLE;
        lx_hold_ch    = CH_NUL;
        lx_hold_vld   = 1'b0;
        lx_hold_kind  = KIND_END;
        lx_hold_first = 1'b0;
        lx_dot        = 1'b0;
        lx_line       = line_t'(1);
        lx_tok_line   = line_t'(1);
    endtask

    task automatic emit(input kind_t k, input logic [7:0] ch, input logic pres,
                        input logic fst, input logic lst, input line_t ln,
                        input err_t e);
        step_tok[step_cnt] = '{k, ch, pres, fst, lst, OUT_LINE_W'(ln), e};
        step_cnt++;
    endtask

    task automatic emit_held(input logic lst);
        emit(lx_hold_kind, lx_hold_ch, 1'b1, lx_hold_first, lst, lx_tok_line, ERR_NONE);
    endtask

    task automatic emit_error(input logic [7:0] ch, input err_t e);
        emit(KIND_END, ch, 1'b0, 1'b1, 1'b1, lx_line, e);
        lx_mode     = M_ERROR;
        lx_hold_vld = 1'b0;
    endtask

    task automatic hold_char(input logic [7:0] c, input kind_t k, input logic fst);
        lx_hold_ch    = c;
        lx_hold_kind  = k;
        lx_hold_first = fst;
        lx_hold_vld   = 1'b1;
        if (fst)
            lx_tok_line = lx_line;
    endtask

    // A byte seen between tokens is skipped as a blank, opens a token or comment, or stands alone.
    task automatic open_token(input logic [7:0] c);
        kind_t k;
        k = single_kind(c);
        if (c == CH_SPACE || c == CH_LF || c == CH_TAB)
            return;
        if (c == CH_DOLLAR)
            lx_mode = M_COMMENT;
        else if (c == CH_QUOTE)
        begin
            lx_mode     = M_STRING;
            lx_hold_vld = 1'b0;
            lx_tok_line = lx_line;
        end
        else if (is_letter(c) || c == CH_UNDER)
        begin
            lx_mode = M_IDENT;
            hold_char(c, KIND_IDENT, 1'b1);
        end
        else if (is_numeral(c))
        begin
            lx_mode = M_NUMBER;
            lx_dot  = 1'b0;
            hold_char(c, KIND_NUMBER, 1'b1);
        end
        else if (c == CH_DOT)
            emit_error(c, ERR_NUMBER);
        else if (c == CH_EQ || c == CH_LT || c == CH_GT || c == CH_BANG)
        begin
            lx_mode = M_OP;
            case (c)
                CH_EQ:   hold_char(c, KIND_ASSIGN, 1'b1);
                CH_LT:   hold_char(c, KIND_LT, 1'b1);
                CH_GT:   hold_char(c, KIND_GT, 1'b1);
                default: hold_char(c, KIND_NE, 1'b1);
            endcase
        end
        else if (k != KIND_END)
            emit(k, c, 1'b1, 1'b1, 1'b1, lx_line, ERR_NONE);
        else
            emit_error(c, ERR_CHAR);
    endtask

    task automatic lex_predict(input logic [7:0] c, input logic eot);
        kind_t pair_kind;
        step_cnt = 0;
        if (eot || c == CH_NUL)
        begin
            case (lx_mode)
                M_IDENT, M_NUMBER:
                    emit_held(1'b1);
                M_OP:
                    if (lx_hold_ch == CH_BANG)
                        emit(KIND_END, CH_BANG, 1'b0, 1'b1, 1'b1, lx_line, ERR_BANG);
                    else
                        emit_held(1'b1);
                M_STRING:
                    if (lx_hold_vld)
                        emit_held(1'b1);
                default:
                    ;
            endcase
            // An open string reports the unterminated error in place of the end item.
            emit(KIND_END, CH_NUL, 1'b0, 1'b1, 1'b1, lx_line,
                 (lx_mode == M_STRING) ? ERR_UNTERM : ERR_NONE);
            lexer_clear();
            return;
        end

        if (c == CH_LF && lx_line != LINE_MAX)
            lx_line = lx_line + line_t'(1);

        case (lx_mode)
            M_ERROR:
                return;
            M_COMMENT:
            begin
                if (c == CH_DOLLAR)
                    lx_mode = M_IDLE;
                return;
            end
            M_STRING:
            begin
                if (c == CH_QUOTE)
                begin
                    if (lx_hold_vld)
                        emit_held(1'b1);
                    else
                        emit(KIND_STRING, CH_NUL, 1'b0, 1'b1, 1'b1, lx_tok_line, ERR_NONE);
                    lx_hold_vld = 1'b0;
                    lx_mode     = M_IDLE;
                end
                else
                begin
                    if (lx_hold_vld)
                        emit_held(1'b0);
                    lx_hold_first = !lx_hold_vld;
                    lx_hold_ch    = c;
                    lx_hold_kind  = KIND_STRING;
                    lx_hold_vld   = 1'b1;
                end
                return;
            end
            M_IDENT:
            begin
                if (is_letter(c) || is_numeral(c) || c == CH_UNDER)
                begin
                    emit_held(1'b0);
                    hold_char(c, KIND_IDENT, 1'b0);
                    return;
                end
                emit_held(1'b1);
                lx_hold_vld = 1'b0;
                lx_mode     = M_IDLE;
            end
            M_NUMBER:
            begin
                if (is_numeral(c) || c == CH_DOT)
                begin
                    if (c == CH_DOT && lx_dot)
                    begin
                        emit_held(1'b1);
                        emit_error(c, ERR_NUMBER);
                        return;
                    end
                    if (c == CH_DOT)
                        lx_dot = 1'b1;
                    emit_held(1'b0);
                    hold_char(c, KIND_NUMBER, 1'b0);
                    return;
                end
                emit_held(1'b1);
                lx_hold_vld = 1'b0;
                lx_mode     = M_IDLE;
            end
            M_OP:
            begin
                if (c == CH_EQ)
                begin
                    pair_kind = (lx_hold_ch == CH_BANG) ? KIND_NE
                                                        : lx_hold_kind + kind_t'(1);
                    emit(pair_kind, lx_hold_ch, 1'b1, 1'b1, 1'b0, lx_tok_line, ERR_NONE);
                    emit(pair_kind, c, 1'b1, 1'b0, 1'b1, lx_tok_line, ERR_NONE);
                    lx_hold_vld = 1'b0;
                    lx_mode     = M_IDLE;
                    return;
                end
                if (lx_hold_ch == CH_BANG)
                begin
                    emit_error(CH_BANG, ERR_BANG);
                    return;
                end
                emit_held(1'b1);
                lx_hold_vld = 1'b0;
                lx_mode     = M_IDLE;
            end
            default:
                lx_mode = M_IDLE;
        endcase
        open_token(c);
    endtask

    task automatic push_byte(input logic [7:0] c, input logic eot);
        stim_q.push_back('{c, eot, 1'b0, '0});
    endtask

    function automatic logic [7:0] any_nonzero_except(input logic [7:0] avoid);
        logic [7:0] c;
        c = 8'($urandom_range(1, 255));
        if (c == avoid)
            c = CH_SPACE;
        return c;
    endfunction

    function automatic logic [7:0] ident_char(input logic lead);
        int r;
        r = lead ? $urandom_range(0, 52) : $urandom_range(0, 62);
        if (r < 26)
            return 8'("a" + r);
        if (r < 52)
            return 8'("A" + r - 26);
        if (lead || r == 62)
            return CH_UNDER;
        return 8'("0" + r - 52);
    endfunction

    task automatic gen_token();
        int sel;
        int n;
        logic [7:0] c;
        sel = $urandom_range(0, 99);
        if (sel < 22)
        begin
            push_byte(ident_char(1'b1), 1'b0);
            n = $urandom_range(0, 6);
            repeat (n) push_byte(ident_char(1'b0), 1'b0);
        end
        else if (sel < 38)
        begin
            n = $urandom_range(1, 4);
            repeat (n) push_byte(8'("0" + $urandom_range(0, 9)), 1'b0);
            if ($urandom_range(0, 1) == 1)
            begin
                push_byte(CH_DOT, 1'b0);
                n = $urandom_range(0, 3);
                repeat (n) push_byte(8'("0" + $urandom_range(0, 9)), 1'b0);
            end
        end
        else if (sel < 50)
        begin
            push_byte(CH_QUOTE, 1'b0);
            n = $urandom_range(0, 5);
            repeat (n) push_byte(any_nonzero_except(CH_QUOTE), 1'b0);
            push_byte(CH_QUOTE, 1'b0);
        end
        else if (sel < 64)
        begin
            c = OP_CHARS[$urandom_range(0, 3)];
            push_byte(c, 1'b0);
            if ((c == CH_BANG) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 1) == 1))
                push_byte(CH_EQ, 1'b0);
        end
        else if (sel < 88)
            push_byte(PUNCT_CHARS[$urandom_range(0, 11)], 1'b0);
        else if (sel < 94)
        begin
            push_byte(CH_DOLLAR, 1'b0);
            n = $urandom_range(0, 6);
            repeat (n) push_byte(any_nonzero_except(CH_DOLLAR), 1'b0);
            push_byte(CH_DOLLAR, 1'b0);
        end
        else
            push_byte(BLANK_CHARS[$urandom_range(0, 2)], 1'b0);
    endtask

    // Mostly well-formed texts; a few carry a stray byte or a broken ending.
    task automatic gen_text();
        int ntok;
        int flaw;
        int n;
        ntok = $urandom_range(1, 12);
        flaw = $urandom_range(0, 99);
        for (int i = 0; i < ntok; i++)
        begin
            gen_token();
            if (flaw < 8 && i == ntok / 2)
                push_byte(8'($urandom_range(1, 255)), 1'b0);
            if ($urandom_range(0, 1) == 1)
            begin
                n = $urandom_range(1, 2);
                repeat (n) push_byte(BLANK_CHARS[$urandom_range(0, 2)], 1'b0);
            end
        end
        if (flaw >= 8 && flaw < 13)
        begin
            push_byte(CH_QUOTE, 1'b0);
            n = $urandom_range(0, 3);
            repeat (n) push_byte(any_nonzero_except(CH_QUOTE), 1'b0);
        end
        else if (flaw >= 13 && flaw < 17)
            push_byte(CH_BANG, 1'b0);
        else if (flaw >= 17 && flaw < 20)
            push_byte(CH_DOT, 1'b0);
        else if (flaw >= 20 && flaw < 23)
            push_byte("7", 1'b0);
        if ($urandom_range(0, 1) == 1)
            push_byte(8'($urandom_range(0, 255)), 1'b1);
        else
            push_byte(CH_NUL, 1'b0);
    endtask

    task automatic check_field(input string name, input int unsigned want_v,
                               input int unsigned got_v);
        if (want_v != got_v)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want_v, got_v);
            fail_cnt++;
        end
    endtask

    always @(posedge clk)
    begin
        tok_t want;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                lex_predict(s_axis_tdata, s_axis_tlast);
                if (stim_q[accept_idx].fixed)
                    token_q.push_back(stim_q[accept_idx].want);
                else
                    for (int i = 0; i < step_cnt; i++)
                        token_q.push_back(step_tok[i]);
                if (s_axis_tlast || s_axis_tdata == CH_NUL)
                    n_texts++;
                accept_idx++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                n_results++;
                if (m_axis_tuser[9:7] != ERR_NONE)
                    n_err_items++;
                if (token_q.size() == 0)
                begin
                    $error("unexpected token transfer: char %0d, kind %0d",
                           m_axis_tdata[7:0], m_axis_tuser[4:0]);
                    fail_cnt++;
                end
                else
                begin
                    want = token_q.pop_front();
                    check_field("token_kind", want.kind, m_axis_tuser[4:0]);
                    check_field("token_char", want.ch, m_axis_tdata[7:0]);
                    check_field("char_present", want.present, m_axis_tuser[5]);
                    check_field("token_first", want.first, m_axis_tuser[6]);
                    check_field("token_last", want.last, m_axis_tlast);
                    check_field("line_number", want.line, m_axis_tdata[31:8]);
                    check_field("error_code", want.err, m_axis_tuser[9:7]);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cyc <= 0;
        else
        begin
            quiet_cyc <= quiet_cyc + 1;
            if (quiet_cyc == QUIET_LIMIT)
            begin
                $display("Watchdog: no transfer for %0d cycles, %0d tokens outstanding",
                         QUIET_LIMIT, token_q.size());
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        int  stall;
        int  rx_n;
        bit  calm;
        rx_n = 0;
        calm = 1'b0;
        m_axis_tready <= 1'b1;
        forever
        begin
            @(posedge clk);
            while (!(m_axis_tvalid && m_axis_tready))
                @(posedge clk);
            rx_n++;
            if (rx_n % 32 == 0)
                calm = ($urandom_range(0, 2) == 0);
            if (rx_n == RX_HOLD_AT)
                stall = RX_HOLD_LEN;
            else
                stall = calm ? 0 : $urandom_range(0, 16);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        int gap;
        bit calm;
        lexer_clear();
        calm = 1'b0;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= CH_NUL;
        s_axis_tlast  <= 1'b0;
        for (int i = 0; i < DIR_LEN; i++)
            stim_q.push_back(DIRECTED[i]);
        while (stim_q.size() < DIR_LEN + RAND_ITEMS)
            gen_text();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        for (int idx = 0; idx < stim_q.size(); idx++)
        begin
            // The sender waits for the output to drain before the random part and once
            // inside it.
            if (idx == DIR_LEN || idx == DIR_LEN + 300)
            begin
                s_axis_tvalid <= 1'b0;
                @(negedge clk);
                while (token_q.size() != 0)
                    @(negedge clk);
                @(posedge clk);
            end
            if (idx % 40 == 0)
                calm = ($urandom_range(0, 2) == 0);
            gap = calm ? 0 : $urandom_range(0, 16);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= stim_q[idx].text;
            s_axis_tlast  <= stim_q[idx].eot;
            @(posedge clk);
            while (!s_axis_tready)
                @(posedge clk);
        end
        s_axis_tvalid <= 1'b0;

        @(negedge clk);
        while (token_q.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d source bytes (%0d directed) in %0d texts.",
                 accept_idx, DIR_LEN, n_texts);
        $display("Checked %0d token transfers, %0d of them error items; %0d failures.",
                 n_results, n_err_items, fail_cnt);
        if (fail_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
